// File: rtl/hmmb_pkg.sv
package hmmb_pkg;

  localparam int VIDEO_BYTES  = 8192;
  localparam int WORK_BYTES   = 8192;
  localparam int SPRITE_BYTES = 160;
  localparam int WAW = $clog2(WORK_BYTES);
  localparam int SAW = $clog2(SPRITE_BYTES);

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_BUTTON = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Store that a bus address decodes to.
  typedef enum logic [3:0] {
    SEL_CART, SEL_VRAM, SEL_WRAM, SEL_OAM, SEL_UNUSED, SEL_JOYP,
    SEL_IF, SEL_DIV, SEL_DMA, SEL_IO, SEL_HRAM, SEL_IE
  } sel_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACCESS, ST_OUT, ST_DMA_RD, ST_DMA_WR
  } state_t;

  typedef struct packed {
    sel_t        sel;
    logic [12:0] offset;
  } decode_t;

  localparam logic [7:0] IF_UPPER    = 8'hE0;
  localparam logic [7:0] FLAG_MASK   = 8'h1F;
  localparam logic [7:0] JOYP_KEEP   = 8'hCF;
  localparam logic [7:0] JOYP_SEL    = 8'h30;
  localparam logic [7:0] JOYP_UPPER  = 8'hC0;
  localparam logic [7:0] JOYP_IRQ    = 8'h10;
  localparam logic [7:0] OPEN_BUS    = 8'hFF;
  localparam logic [6:0] IO_JOYP     = 7'h00;
  localparam logic [6:0] IO_DIV      = 7'h04;
  localparam logic [6:0] IO_IF       = 7'h0F;

  // Addresses of the special registers.
  localparam logic [15:0] ADDR_JOYP  = 16'hFF00;
  localparam logic [15:0] ADDR_DIV   = 16'hFF04;
  localparam logic [15:0] ADDR_IF    = 16'hFF0F;
  localparam logic [15:0] ADDR_DMA   = 16'hFF46;
  localparam logic [15:0] ADDR_IE    = 16'hFFFF;

  function automatic decode_t decode(input logic [15:0] a);
    decode_t d;
    d.offset = a[12:0];
    if (a == ADDR_IF) d.sel = SEL_IF;
    else if (a == ADDR_IE) d.sel = SEL_IE;
    else if (a[15] == 1'b0 || a[15:13] == 3'b101) d.sel = SEL_CART;
    else if (a[15:13] == 3'b100) d.sel = SEL_VRAM;
    else if (a <= 16'hFDFF) d.sel = SEL_WRAM;
    else if (a <= 16'hFE9F) d.sel = SEL_OAM;
    else if (a <= 16'hFEFF) d.sel = SEL_UNUSED;
    else if (a == ADDR_JOYP) d.sel = SEL_JOYP;
    else if (a == ADDR_DIV) d.sel = SEL_DIV;
    else if (a == ADDR_DMA) d.sel = SEL_DMA;
    else if (a <= 16'hFF7F) d.sel = SEL_IO;
    else d.sel = SEL_HRAM;
    if (d.sel == SEL_HRAM) d.offset = {6'd0, a[6:0]};
    return d;
  endfunction

endpackage

// File: rtl/hmmb_if.sv
interface hmmb_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [7:0]  cart_read_data;
  logic [2:0]  key_index;
  logic        pressed;
  modport source (output valid, cmd, address, write_data, cart_read_data, key_index,
                  pressed, input ready);
  modport sink (input valid, cmd, address, write_data, cart_read_data, key_index,
                pressed, output ready);
endinterface

interface hmmb_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        cart_write;
  logic [15:0] cart_address;
  logic [7:0]  cart_data;
  modport source (output valid, read_data, cart_write, cart_address, cart_data,
                  input ready);
  modport sink (input valid, read_data, cart_write, cart_address, cart_data,
                output ready);
endinterface

// File: rtl/hmmb_ram.sv
// Single-port synchronous RAM with registered read data.
module hmmb_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/handheld_memory_map_bus.sv
// Memory map for an 8-bit handheld bus.
// Channels: in_ch carries one command beat (read, write or button event),
// out_ch returns exactly one result beat per command.
// Sequence: a command is decoded and its store is read (and written) at the
// accept edge, the registered store data is muxed and captured in the
// access state, and the result beat is valid in the out state that follows.
// A new command is taken once the state machine is back in idle after the
// result beat leaves.
// A write to the DMA register copies 160 bytes into the sprite table, each
// byte read in the DMA read state and written in the DMA write state, through
// the single RAM port of the source store; its result beat follows the last
// byte.
// Reset: a clearing pass walks all 8192 rows of video and work RAM, one row
// per cycle, while in_ch.ready stays low. The sprite table, I/O registers
// and high RAM are cleared by the same pass. The joypad select register
// resets to 0xFF.
// Stall: while out_ch.ready is low the result beat holds and no new command
// is taken.
module handheld_memory_map_bus (
  input logic clk,
  input logic rst,
  hmmb_in_if.sink    in_ch,
  hmmb_out_if.source out_ch
);

  hmmb_pkg::state_t state, state_next;

  logic [12:0] clr_cnt;
  logic        clr_done;
  logic        clearing;
  logic [1:0]  cmd_r;
  logic [15:0] addr_r;
  logic [7:0]  wdata_r;
  logic [7:0]  cdata_r;
  hmmb_pkg::decode_t dec_r;
  hmmb_pkg::decode_t in_dec;
  logic [7:0]  dma_page;
  logic [7:0]  dma_idx;
  logic [7:0]  irq_enable;
  logic [7:0]  buttons_held;
  logic [7:0]  joyp_reg;
  logic [7:0]  if_reg;

  // Memory access bus shared by commands, DMA and the clearing pass.
  logic [15:0] acc_addr;
  hmmb_pkg::decode_t acc_dec;
  logic [7:0]  acc_wdata;

  logic        vram_we, wram_we, oam_we, io_we, hram_we;
  logic [7:0]  vram_q, wram_q, oam_q, io_q, hram_q;
  logic [hmmb_pkg::SAW-1:0] oam_addr;
  logic [hmmb_pkg::WAW-1:0] wram_addr;
  logic [7:0]  rd_byte;
  logic [7:0]  dma_byte;

  logic [7:0] o_read_data;
  logic       o_cart_write;
  logic [15:0] o_cart_address;
  logic [7:0] o_cart_data;

  assign acc_dec = hmmb_pkg::decode(acc_addr);
  assign in_dec  = hmmb_pkg::decode(in_ch.address);

  // Work RAM echo: 0xE000-0xFDFF maps to the same 13-bit offset.
  assign wram_addr = clearing ? clr_cnt : acc_dec.offset;
  assign oam_addr  = clearing ? clr_cnt[hmmb_pkg::SAW-1:0] :
                     (state == hmmb_pkg::ST_DMA_WR) ? dma_idx : acc_dec.offset[7:0];

  hmmb_ram #(.DEPTH(hmmb_pkg::VIDEO_BYTES)) u_vram (
    .clk(clk), .we(vram_we),
    .addr(clearing ? clr_cnt : acc_dec.offset),
    .wdata(acc_wdata), .rdata(vram_q));
  hmmb_ram #(.DEPTH(hmmb_pkg::WORK_BYTES)) u_wram (
    .clk(clk), .we(wram_we), .addr(wram_addr), .wdata(acc_wdata), .rdata(wram_q));
  hmmb_ram #(.DEPTH(hmmb_pkg::SPRITE_BYTES)) u_oam (
    .clk(clk), .we(oam_we), .addr(oam_addr), .wdata(acc_wdata), .rdata(oam_q));
  hmmb_ram #(.DEPTH(128)) u_io (
    .clk(clk), .we(io_we), .addr(clearing ? clr_cnt[6:0] : acc_addr[6:0]),
    .wdata(acc_wdata), .rdata(io_q));
  hmmb_ram #(.DEPTH(128)) u_hram (
    .clk(clk), .we(hram_we), .addr(clearing ? clr_cnt[6:0] : acc_addr[6:0]),
    .wdata(acc_wdata), .rdata(hram_q));

  // The pass runs from reset until every row, the last one included, is zero.
  assign clearing = !clr_done;

  // Address driven onto the stores.
  always_comb begin
    acc_addr = addr_r;
    if (state == hmmb_pkg::ST_DMA_RD) acc_addr = {dma_page, dma_idx};
    else if (state == hmmb_pkg::ST_IDLE) acc_addr = in_ch.address;
  end

  // Store writes: clear pass, command writes (in the accept cycle) and DMA.
  always_comb begin
    vram_we = 1'b0; wram_we = 1'b0; oam_we = 1'b0; io_we = 1'b0; hram_we = 1'b0;
    acc_wdata = in_ch.write_data;
    if (clearing) begin
      vram_we = 1'b1; wram_we = 1'b1; acc_wdata = '0;
      oam_we = (clr_cnt < 13'(hmmb_pkg::SPRITE_BYTES));
      io_we = (clr_cnt < 13'd128);
      hram_we = (clr_cnt < 13'd128);
    end else if (state == hmmb_pkg::ST_DMA_WR) begin
      oam_we = 1'b1; acc_wdata = dma_byte;
    end else if (in_ch.valid && in_ch.ready && in_ch.cmd == hmmb_pkg::CMD_WRITE) begin
      vram_we = (in_dec.sel == hmmb_pkg::SEL_VRAM);
      wram_we = (in_dec.sel == hmmb_pkg::SEL_WRAM);
      oam_we  = (in_dec.sel == hmmb_pkg::SEL_OAM);
      io_we   = (in_dec.sel == hmmb_pkg::SEL_IO) || (in_dec.sel == hmmb_pkg::SEL_DIV);
      hram_we = (in_dec.sel == hmmb_pkg::SEL_HRAM);
      // Divider register: a write clears it whatever the data.
      if (in_dec.sel == hmmb_pkg::SEL_DIV) acc_wdata = '0;
    end
  end

  // Read mux over the decoded store, registered RAM output already present.
  function automatic logic [7:0] pick(input hmmb_pkg::decode_t d, input logic [7:0] cart,
                                      input logic [7:0] v, input logic [7:0] w,
                                      input logic [7:0] o, input logic [7:0] io,
                                      input logic [7:0] h, input logic [7:0] ie,
                                      input logic [7:0] fl, input logic [7:0] jp);
    logic [7:0] r;
    case (d.sel)
      hmmb_pkg::SEL_CART: r = cart;
      hmmb_pkg::SEL_VRAM: r = v;
      hmmb_pkg::SEL_WRAM: r = w;
      hmmb_pkg::SEL_OAM:  r = o;
      hmmb_pkg::SEL_UNUSED: r = hmmb_pkg::OPEN_BUS;
      hmmb_pkg::SEL_JOYP: r = jp;
      hmmb_pkg::SEL_IF:   r = fl | hmmb_pkg::IF_UPPER;
      hmmb_pkg::SEL_IE:   r = ie;
      hmmb_pkg::SEL_DIV, hmmb_pkg::SEL_DMA, hmmb_pkg::SEL_IO: r = io;
      hmmb_pkg::SEL_HRAM: r = h;
      default: r = '0;
    endcase
    return r;
  endfunction

  logic [7:0] joyp_val;
  always_comb begin
    logic [3:0] nib;
    nib = 4'hF;
    if (!joyp_reg[4]) nib = nib & ~buttons_held[3:0];
    if (!joyp_reg[5]) nib = nib & ~buttons_held[7:4];
    joyp_val = hmmb_pkg::JOYP_UPPER | (joyp_reg & hmmb_pkg::JOYP_SEL) | {4'd0, nib};
  end

  hmmb_pkg::decode_t dma_dec_r;
  assign rd_byte  = pick(dec_r, cdata_r, vram_q, wram_q, oam_q, io_q, hram_q,
                         irq_enable, if_reg, joyp_val);
  assign dma_byte = pick(dma_dec_r, hmmb_pkg::OPEN_BUS, vram_q, wram_q, oam_q, io_q,
                         hram_q, irq_enable, if_reg, joyp_val);

  assign in_ch.ready = (state == hmmb_pkg::ST_IDLE) && clr_done && !rst;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      hmmb_pkg::ST_IDLE:
        if (in_ch.valid && in_ch.ready) state_next = hmmb_pkg::ST_ACCESS;
      hmmb_pkg::ST_ACCESS:
        if (cmd_r == hmmb_pkg::CMD_WRITE && dec_r.sel == hmmb_pkg::SEL_DMA)
          state_next = hmmb_pkg::ST_DMA_RD;
        else state_next = hmmb_pkg::ST_OUT;
      hmmb_pkg::ST_DMA_RD: state_next = hmmb_pkg::ST_DMA_WR;
      hmmb_pkg::ST_DMA_WR:
        state_next = (dma_idx == 8'(hmmb_pkg::SPRITE_BYTES - 1)) ?
                     hmmb_pkg::ST_OUT : hmmb_pkg::ST_DMA_RD;
      hmmb_pkg::ST_OUT:
        if (out_ch.ready) state_next = hmmb_pkg::ST_IDLE;
      default: state_next = hmmb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= hmmb_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Clearing pass counter; the pass is done once the last row is written.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      clr_done <= 1'b0;
    end else if (!clr_done) begin
      if (clr_cnt == '1) clr_done <= 1'b1;
      else clr_cnt <= clr_cnt + 13'd1;
    end
  end

  // Command capture and register updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable <= '0;
      buttons_held <= '0;
      joyp_reg <= 8'hFF;
      if_reg <= '0;
      dma_idx <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cmd_r <= in_ch.cmd;
        addr_r <= in_ch.address;
        wdata_r <= in_ch.write_data;
        cdata_r <= in_ch.cart_read_data;
        dec_r <= in_dec;
        dma_page <= in_ch.write_data;
        dma_idx <= '0;
        if (in_ch.cmd == hmmb_pkg::CMD_WRITE) begin
          case (in_dec.sel)
            hmmb_pkg::SEL_IF: if_reg <= in_ch.write_data & hmmb_pkg::FLAG_MASK;
            hmmb_pkg::SEL_IE: irq_enable <= in_ch.write_data & hmmb_pkg::FLAG_MASK;
            hmmb_pkg::SEL_JOYP:
              joyp_reg <= (in_ch.write_data & hmmb_pkg::JOYP_SEL) |
                          (joyp_reg & hmmb_pkg::JOYP_KEEP);
            default: ;
          endcase
        end else if (in_ch.cmd == hmmb_pkg::CMD_BUTTON) begin
          if (in_ch.pressed) begin
            buttons_held[in_ch.key_index] <= 1'b1;
            if_reg <= if_reg | hmmb_pkg::JOYP_IRQ;
          end else begin
            buttons_held[in_ch.key_index] <= 1'b0;
          end
        end
      end
      if (state == hmmb_pkg::ST_DMA_RD) dma_dec_r <= acc_dec;
      if (state == hmmb_pkg::ST_DMA_WR) dma_idx <= dma_idx + 8'd1;
    end
  end

  // Result capture at the end of the access cycle.
  always_ff @(posedge clk) begin
    if (state == hmmb_pkg::ST_ACCESS) begin
      o_read_data <= (cmd_r == hmmb_pkg::CMD_READ) ? rd_byte : 8'd0;
      o_cart_write <= (cmd_r == hmmb_pkg::CMD_WRITE) && (dec_r.sel == hmmb_pkg::SEL_CART);
      o_cart_address <= (cmd_r == hmmb_pkg::CMD_WRITE && dec_r.sel == hmmb_pkg::SEL_CART)
                        ? addr_r : 16'd0;
      o_cart_data <= (cmd_r == hmmb_pkg::CMD_WRITE && dec_r.sel == hmmb_pkg::SEL_CART)
                     ? wdata_r : 8'd0;
    end
  end

  assign out_ch.valid = (state == hmmb_pkg::ST_OUT);
  assign out_ch.read_data = o_read_data;
  assign out_ch.cart_write = o_cart_write;
  assign out_ch.cart_address = o_cart_address;
  assign out_ch.cart_data = o_cart_data;

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != hmmb_pkg::ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_dma_bound: assert property (@(posedge clk) disable iff (rst)
    (state == hmmb_pkg::ST_DMA_WR) |-> (dma_idx < 8'(hmmb_pkg::SPRITE_BYTES)))
    else $error("dma index overrun");
  a_out_follows_access: assert property (@(posedge clk) disable iff (rst)
    (state == hmmb_pkg::ST_ACCESS && dec_r.sel != hmmb_pkg::SEL_DMA) |=> out_ch.valid)
    else $error("missing result");
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    !clr_done |-> !in_ch.ready) else $error("accept during clear");

endmodule
